// ===== design/dpd_pkg.sv =====
//------------------------------------------------------------------------------
// Presence detector package
// Register indexes, reset values and default parameters shared by the block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpd_pkg;

	// Default sample width
	localparam int unsigned SAMPLE_BITS_DEF = 18;

	// Configuration register widths
	localparam int unsigned OFFSET_BITS = 18;
	localparam int unsigned COUNT_BITS  = 4;
	localparam int unsigned CFG_DATA_BITS = 18;
	localparam int unsigned CFG_INDEX_BITS = 3;

	// Register reset values
	localparam logic [OFFSET_BITS-1:0] OFFSET_UP_RST    = 18'd9000;
	localparam logic [OFFSET_BITS-1:0] OFFSET_DOWN_RST  = 18'd6000;
	localparam logic [COUNT_BITS-1:0]  COUNT_LIMIT_RST  = 4'd5;
	localparam logic [COUNT_BITS-1:0]  CONFIRM_RST      = 4'd3;
	localparam logic [OFFSET_BITS-1:0] SPIKE_MARGIN_RST = 18'd4000;

	// Register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_OFFSET_UP     = 3'd0,
		REG_OFFSET_DOWN   = 3'd1,
		REG_COUNT_LIMIT   = 3'd2,
		REG_CONFIRM_COUNT = 3'd3,
		REG_SPIKE_MARGIN  = 3'd4
	} cfg_reg_t;

	typedef logic [COUNT_BITS-1:0] count_t;

endpackage

// ===== design/debounced_presence_detector.sv =====
//------------------------------------------------------------------------------
// Debounced presence detector
// Hysteresis thresholds over a tracked baseline, debounce counters and
// baseline averaging, one sample per request.
//------------------------------------------------------------------------------
// The block takes one sample request per clock while the input is not stalled
// and returns one result per sample: a sample is captured in the input
// register, then the threshold compares, counter and presence update and the
// 7/8 baseline average run in one pass of logic into the result register and
// the state registers. The state feedback loop closes through the state
// registers alone, so consecutive samples follow back to back. The output
// register decouples the sides; the input stalls only while a result waits and
// the input register is full.
`timescale 1ns / 1ps

module debounced_presence_detector #(
	parameter int unsigned SAMPLE_BITS = dpd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [dpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [dpd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// sample channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [SAMPLE_BITS-1:0]             sample,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               present,
	output logic                               arrived,
	output logic                               removed,
	output logic [SAMPLE_BITS-1:0]             baseline_level
);
	import dpd_pkg::*;

	// threshold width: baseline plus an offset, never wraps
	localparam int unsigned WIDE_BITS =
		((SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS) + 1;
	localparam int unsigned AVG_BITS = SAMPLE_BITS + 3;

	// configuration registers
	logic [OFFSET_BITS-1:0] offset_up_q;
	logic [OFFSET_BITS-1:0] offset_down_q;
	count_t                 count_limit_q;
	count_t                 confirm_q;
	logic [OFFSET_BITS-1:0] spike_margin_q;

	// detector state
	logic [SAMPLE_BITS-1:0] baseline_q;
	logic                   primed_q;
	count_t                 above_q;
	count_t                 below_q;
	logic                   presence_q;

	// input stage
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;

	// result register
	logic                   out_valid_q;
	logic                   present_q;
	logic                   arrived_q;
	logic                   removed_q;
	logic [SAMPLE_BITS-1:0] level_q;

	logic                   advance;
	logic [WIDE_BITS-1:0]   upper;
	logic [WIDE_BITS-1:0]   lower;
	logic [WIDE_BITS-1:0]   spike_lim;
	logic [WIDE_BITS-1:0]   sample_w;
	logic [AVG_BITS-1:0]    avg_sum;
	count_t                 above_d;
	count_t                 below_d;
	logic                   presence_d;
	logic [SAMPLE_BITS-1:0] baseline_d;

	// handshake
	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_up_q    <= OFFSET_UP_RST;
			offset_down_q  <= OFFSET_DOWN_RST;
			count_limit_q  <= COUNT_LIMIT_RST;
			confirm_q      <= CONFIRM_RST;
			spike_margin_q <= SPIKE_MARGIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OFFSET_UP:     offset_up_q    <= cfg_data[OFFSET_BITS-1:0];
				REG_OFFSET_DOWN:   offset_down_q  <= cfg_data[OFFSET_BITS-1:0];
				REG_COUNT_LIMIT:   count_limit_q  <= cfg_data[COUNT_BITS-1:0];
				REG_CONFIRM_COUNT: confirm_q      <= cfg_data[COUNT_BITS-1:0];
				REG_SPIKE_MARGIN:  spike_margin_q <= cfg_data[OFFSET_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= sample;
		end
	end

	// thresholds at full width
	always_comb begin
		sample_w  = WIDE_BITS'(sample_s1);
		upper     = WIDE_BITS'(baseline_q) + WIDE_BITS'(offset_up_q);
		lower     = WIDE_BITS'(baseline_q) + WIDE_BITS'(offset_down_q);
		spike_lim = WIDE_BITS'(baseline_q) + WIDE_BITS'(spike_margin_q);
		avg_sum   = (AVG_BITS'(baseline_q) << 3) - AVG_BITS'(baseline_q)
			+ AVG_BITS'(sample_s1);
	end

	// debounce counters and presence decision
	always_comb begin
		above_d = above_q;
		below_d = below_q;
		if (sample_w > upper) begin
			if (above_q < count_limit_q) above_d = above_q + 1'b1;
			below_d = '0;
		end else if (sample_w < lower) begin
			if (below_q < count_limit_q) below_d = below_q + 1'b1;
			above_d = '0;
		end
		presence_d = presence_q;
		if (!presence_d && above_d >= confirm_q) presence_d = 1'b1;
		if (presence_d && below_d >= confirm_q) presence_d = 1'b0;
	end

	// baseline tracking, only while absent
	always_comb begin
		baseline_d = baseline_q;
		if (!presence_d) begin
			if (!primed_q) begin
				baseline_d = sample_s1;
			end else if (sample_w < spike_lim) begin
				baseline_d = avg_sum[AVG_BITS-1:3];
			end
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q <= '0;
			primed_q   <= 1'b0;
			above_q    <= '0;
			below_q    <= '0;
			presence_q <= 1'b0;
		end else if (advance) begin
			baseline_q <= baseline_d;
			if (!presence_d) primed_q <= 1'b1;
			above_q    <= above_d;
			below_q    <= below_d;
			presence_q <= presence_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			present_q <= presence_d;
			arrived_q <= !presence_q && presence_d;
			removed_q <= presence_q && !presence_d;
			level_q   <= baseline_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign present        = present_q;
	assign arrived        = arrived_q;
	assign removed        = removed_q;
	assign baseline_level = level_q;

`ifndef ASSERT_OFF
	// an edge flag always agrees with the reported presence
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(arrived_q && !present_q) && !(removed_q && present_q))
		else $error("edge flag disagrees with presence");

	// the two debounce counters are never both running
	assert property (@(posedge clk) disable iff (!arst_n)
		!((above_q != '0) && (below_q != '0)))
		else $error("up and down counts both nonzero");

	// a sample held in the input stage is not dropped while the output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |=> valid_s1 && $stable(sample_s1))
		else $error("input stage lost a sample under stall");

	// state only moves when a sample passes to the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(presence_q) && $stable(above_q) && $stable(below_q))
		else $error("detector state changed without a sample");
`endif

endmodule
